// File: design/dated_rate_floor_lookup_defines.svh
// assertion macros for the rate lookup block
`ifndef DATED_RATE_FLOOR_LOOKUP_DEFINES_SVH
`define DATED_RATE_FLOOR_LOOKUP_DEFINES_SVH

// implication checked at every rising clock edge outside reset
`define DRFL_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DRFL_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/drfl_pkg.sv
package drfl_pkg;

  localparam int unsigned TableDepth = 2048;
  localparam int unsigned IdxW       = $clog2(TableDepth);
  localparam int unsigned CntW       = IdxW + 1;
  localparam int unsigned KeyW       = 64;
  localparam int unsigned RateW      = 48;
  localparam int unsigned ProdW      = 63;
  localparam int unsigned LimitW     = 31;
  localparam logic [LimitW-1:0] LimitReset = 31'd65536000;

  localparam logic [2:0] StOk      = 3'd0;
  localparam logic [2:0] StBadDate = 3'd1;
  localparam logic [2:0] StNeg     = 3'd2;
  localparam logic [2:0] StBig     = 3'd3;
  localparam logic [2:0] StNoRate  = 3'd4;
  localparam logic [2:0] StLoaded  = 3'd5;
  localparam logic [2:0] StFull    = 3'd6;

  localparam logic OpLoad  = 1'b0;
  localparam logic OpQuery = 1'b1;

  typedef struct packed {
    logic        op;
    logic [3:0]  date_length;
    logic [31:0] year_text;
    logic [7:0]  first_dash;
    logic [15:0] month_text;
    logic [7:0]  second_dash;
    logic [15:0] day_text;
    logic signed [31:0] amount;
    logic [47:0] rate_value;
  } in_item_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [ProdW-1:0] product;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic capture;     // latch the input item
    logic search_init; // lo=0, hi=count
    logic probe;       // issue read of key[mid]
    logic step;        // update lo/hi from key read
    logic rd_prev;     // read entry lo-1
    logic shift_rd;    // read entry at shift pointer-1
    logic shift_wr;    // write it at shift pointer, decrement
    logic ins_wr;      // write new entry at lo, bump count
    logic ovr_wr;      // overwrite rate at lo-1
    logic mul_lo;      // first partial product
    logic mul_hi;      // second partial product
    logic set_res;     // build result from status code
    logic [2:0] res_status;
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic is_query;
    logic date_ok;
    logic amt_neg;
    logic amt_big;
    logic search_done; // lo == hi
    logic pos_zero;    // lo == 0
    logic key_match;   // key[lo-1] == query key
    logic full;
    logic shift_done;  // shift pointer == lo
  } stat_t;

  function automatic logic [3:0] dig(input logic [7:0] c);
    logic [7:0] t;
    t = c - 8'h30;
    return t[3:0];
  endfunction

  function automatic logic is_dig(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

endpackage

// File: design/dated_rate_floor_lookup.sv
// channel   | handshake              | payload
// ----------+------------------------+---------------------------
// in        | in_valid_i/in_ready_o  | in_item_i  (in_item_t)
// out       | out_valid_o/out_ready_i| out_item_o (out_item_t)
// config    | apb psel/penable/pwrite| paddr/pwdata/prdata
//
// one transaction at a time; the search takes k steps, k <= ceil(log2(count+1))
// a query searches the key memory, reads the entry below the found position,
// then forms the product from two partial products; with no earlier rate it
// returns without the multiply; a load searches the same way, then overwrites
// a matching key, reports a full table, or moves later entries up one by one
// and inserts the new key; rejected queries return from the check state unsearched
// reset clears the entry count and state; memories need no clearing pass
// a held result stalls input until taken
module dated_rate_floor_lookup import drfl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_item_t    in_item_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_item_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [LimitW-1:0] limit_q;
  ctrl_t ctrl;
  stat_t stat;

  // amount limit register at byte address zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LimitReset;
    end else if (psel && penable && pwrite && (paddr == 2'd0)) begin
      limit_q <= pwdata[LimitW-1:0];
    end
  end
  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? {1'b0, limit_q} : 32'd0;

  drfl_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .stat_i(stat), .ctrl_o(ctrl)
  );

  drfl_datapath u_dp (
    .clk_i, .rst_ni, .ctrl_i(ctrl), .stat_o(stat), .item_i(in_item_i),
    .limit_i(limit_q), .res_o(out_item_o)
  );
endmodule

// File: design/drfl_datecheck.sv
module drfl_datecheck import drfl_pkg::*; (
  input  in_item_t item_i,
  output logic     ok_o
);
  logic [13:0] year;
  logic [6:0]  month, day;
  logic [4:0]  dmax;
  logic        leap, digs, y4, y100, y400;
  logic [6:0]  yl; // last two digits
  logic [6:0]  yh; // first two digits

  always_comb begin
    digs = is_dig(item_i.year_text[31:24]) && is_dig(item_i.year_text[23:16]) &&
           is_dig(item_i.year_text[15:8]) && is_dig(item_i.year_text[7:0]) &&
           is_dig(item_i.month_text[15:8]) && is_dig(item_i.month_text[7:0]) &&
           is_dig(item_i.day_text[15:8]) && is_dig(item_i.day_text[7:0]);
    yh = 7'(dig(item_i.year_text[31:24])) * 7'd10 + 7'(dig(item_i.year_text[23:16]));
    yl = 7'(dig(item_i.year_text[15:8])) * 7'd10 + 7'(dig(item_i.year_text[7:0]));
    year = 14'(yh) * 14'd100 + 14'(yl);
    month = 7'(dig(item_i.month_text[15:8])) * 7'd10 + 7'(dig(item_i.month_text[7:0]));
    day = 7'(dig(item_i.day_text[15:8])) * 7'd10 + 7'(dig(item_i.day_text[7:0]));
    // divisible by 4 from last two digits; by 100 when they are zero
    y4   = (yl[1:0] == 2'b00);
    y100 = (yl == 7'd0);
    y400 = (yh[1:0] == 2'b00);
    leap = y100 ? y400 : y4;
    case (month)
      7'd2:                        dmax = leap ? 5'd29 : 5'd28;
      7'd4, 7'd6, 7'd9, 7'd11:     dmax = 5'd30;
      default:                     dmax = 5'd31;
    endcase
    ok_o = (item_i.date_length == 4'd10) && (item_i.first_dash == 8'h2D) &&
           (item_i.second_dash == 8'h2D) && digs && (year != 14'd0) &&
           (month >= 7'd1) && (month <= 7'd12) && (day >= 7'd1) &&
           (day <= 7'(dmax));
  end
endmodule

// File: design/drfl_datapath.sv
module drfl_datapath import drfl_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ctrl_t            ctrl_i,
  output stat_t            stat_o,
  input  in_item_t         item_i,
  input  logic [LimitW-1:0] limit_i,
  output out_item_t        res_o
);
  logic [KeyW-1:0]  key_mem [TableDepth];
  logic [RateW-1:0] rate_mem [TableDepth];

  in_item_t         item_q;
  logic [CntW-1:0]  count_q, count_d;
  logic [CntW-1:0]  lo_q, hi_q, sp_q;
  logic [KeyW-1:0]  rkey_q;
  logic [RateW-1:0] rrate_q;
  logic [47:0]      pl_q;
  logic [ProdW-1:0] res_prod_q;
  logic [2:0]       res_stat_q;
  logic             date_ok;

  logic [KeyW-1:0]  qkey;
  logic [CntW-1:0]  mid, rd_ptr;
  logic             rd_en;
  logic             wr_en;
  logic [IdxW-1:0]  wr_idx;
  logic [KeyW-1:0]  wr_key;
  logic [RateW-1:0] wr_rate;
  logic             wr_key_en;
  logic [63:0]      ph;
  logic [47:0]      pl;

  drfl_datecheck u_date (.item_i(item_q), .ok_o(date_ok));

  assign qkey = {item_q.year_text, item_q.month_text, item_q.day_text};
  assign mid  = lo_q + ((hi_q - lo_q) >> 1);

  // read data is held between reads so later states see the last entry read
  assign rd_en = ctrl_i.probe | ctrl_i.rd_prev | ctrl_i.shift_rd;

  always_comb begin
    rd_ptr = mid;
    if (ctrl_i.rd_prev) rd_ptr = lo_q - CntW'(1);
    if (ctrl_i.shift_rd) rd_ptr = sp_q - CntW'(1);
  end

  always_comb begin
    wr_en = 1'b0; wr_key_en = 1'b0;
    wr_idx = sp_q[IdxW-1:0]; wr_key = rkey_q; wr_rate = rrate_q;
    if (ctrl_i.shift_wr) begin
      wr_en = 1'b1; wr_key_en = 1'b1;
    end else if (ctrl_i.ins_wr) begin
      wr_en = 1'b1; wr_key_en = 1'b1;
      wr_idx = lo_q[IdxW-1:0]; wr_key = qkey; wr_rate = item_q.rate_value;
    end else if (ctrl_i.ovr_wr) begin
      wr_en = 1'b1;
      wr_idx = IdxW'(lo_q - CntW'(1)); wr_rate = item_q.rate_value;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) rate_mem[wr_idx] <= wr_rate;
    if (wr_key_en) key_mem[wr_idx] <= wr_key;
    if (rd_en) begin
      rkey_q  <= key_mem[rd_ptr[IdxW-1:0]];
      rrate_q <= rate_mem[rd_ptr[IdxW-1:0]];
    end
  end

  // 32x16 and 32x32 partial products, one per cycle
  assign pl = 48'({16'd0, item_q.amount[31:0]} * {32'd0, rrate_q[15:0]});
  assign ph = {32'd0, item_q.amount[31:0]} * {32'd0, rrate_q[47:16]};

  assign count_d = ctrl_i.ins_wr ? count_q + CntW'(1) : count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      lo_q       <= '0;
      hi_q       <= '0;
      sp_q       <= '0;
      res_stat_q <= StOk;
      res_prod_q <= '0;
      pl_q       <= '0;
    end else begin
      count_q <= count_d;
      if (ctrl_i.search_init) begin
        lo_q <= '0; hi_q <= count_q; sp_q <= count_q;
      end
      if (ctrl_i.step) begin
        if (rkey_q <= qkey) lo_q <= mid + CntW'(1);
        else hi_q <= mid;
      end
      if (ctrl_i.shift_wr) sp_q <= sp_q - CntW'(1);
      if (ctrl_i.mul_lo) pl_q <= pl >> 16;
      if (ctrl_i.set_res) begin
        res_stat_q <= ctrl_i.res_status;
        res_prod_q <= '0;
      end
      if (ctrl_i.mul_hi) begin
        res_stat_q <= StOk;
        res_prod_q <= ProdW'(ph + {16'd0, pl_q});
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) item_q <= item_i;
  end

  assign stat_o.is_query    = (item_q.op == OpQuery);
  assign stat_o.date_ok     = date_ok;
  assign stat_o.amt_neg     = item_q.amount[31];
  assign stat_o.amt_big     = {1'b0, item_q.amount[30:0]} > {1'b0, limit_i};
  assign stat_o.search_done = (lo_q == hi_q);
  assign stat_o.pos_zero    = (lo_q == '0);
  assign stat_o.key_match   = (rkey_q == qkey);
  assign stat_o.full        = (count_q == CntW'(TableDepth));
  assign stat_o.shift_done  = (sp_q == lo_q);

  assign res_o.status  = res_stat_q;
  assign res_o.product = res_prod_q;
endmodule

// File: design/drfl_ctrl.sv
module drfl_ctrl import drfl_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  input  stat_t stat_i,
  output ctrl_t ctrl_o
);
  typedef enum logic [3:0] {
    SIdle, SCheck, SProbe, SStep, SPrev, SPrevW, SDecide,
    SShRd, SShWr, SMul1, SMul2, SOut
  } state_e;

  state_e state_q;
  logic   out_valid_q;

  assign in_ready_o  = (state_q == SIdle);
  assign out_valid_o = out_valid_q;

  always_comb begin
    ctrl_o = '0;
    ctrl_o.res_status = StOk;
    case (state_q)
      SIdle:  ctrl_o.capture = in_valid_i;
      SCheck: begin
        ctrl_o.search_init = 1'b1;
        if (stat_i.is_query) begin
          ctrl_o.set_res = 1'b1;
          if (!stat_i.date_ok) ctrl_o.res_status = StBadDate;
          else if (stat_i.amt_neg) ctrl_o.res_status = StNeg;
          else if (stat_i.amt_big) ctrl_o.res_status = StBig;
        end
      end
      SProbe: ctrl_o.probe = 1'b1;
      SStep:  ctrl_o.step = 1'b1;
      SPrev:  ctrl_o.rd_prev = 1'b1;
      SDecide: begin
        if (stat_i.is_query) begin
          if (stat_i.pos_zero) begin
            ctrl_o.set_res = 1'b1; ctrl_o.res_status = StNoRate;
          end
        end else if (!stat_i.pos_zero && stat_i.key_match) begin
          ctrl_o.ovr_wr = 1'b1; ctrl_o.set_res = 1'b1; ctrl_o.res_status = StLoaded;
        end else if (stat_i.full) begin
          ctrl_o.set_res = 1'b1; ctrl_o.res_status = StFull;
        end else if (stat_i.shift_done) begin
          ctrl_o.ins_wr = 1'b1; ctrl_o.set_res = 1'b1; ctrl_o.res_status = StLoaded;
        end
      end
      SShRd: begin
        if (stat_i.shift_done) begin
          ctrl_o.ins_wr = 1'b1; ctrl_o.set_res = 1'b1; ctrl_o.res_status = StLoaded;
        end else ctrl_o.shift_rd = 1'b1;
      end
      SShWr:  ctrl_o.shift_wr = 1'b1;
      SMul1:  ctrl_o.mul_lo = 1'b1;
      SMul2:  ctrl_o.mul_hi = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        SIdle: if (in_valid_i) state_q <= SCheck;
        SCheck: begin
          if (stat_i.is_query && (!stat_i.date_ok || stat_i.amt_neg || stat_i.amt_big)) begin
            state_q <= SOut; out_valid_q <= 1'b1;
          end else state_q <= SProbe;
        end
        // probe reads key[mid]; an empty interval ends the search
        SProbe: state_q <= stat_i.search_done ? SPrev : SStep;
        SStep:  state_q <= SProbe;
        SPrev:  state_q <= SPrevW;
        SPrevW: state_q <= SDecide;
        SDecide: begin
          if (stat_i.is_query) begin
            if (stat_i.pos_zero) begin
              state_q <= SOut; out_valid_q <= 1'b1;
            end else state_q <= SMul1;
          end else if ((!stat_i.pos_zero && stat_i.key_match) || stat_i.full ||
                       stat_i.shift_done) begin
            state_q <= SOut; out_valid_q <= 1'b1;
          end else state_q <= SShRd;
        end
        SShRd: begin
          if (stat_i.shift_done) begin
            state_q <= SOut; out_valid_q <= 1'b1;
          end else state_q <= SShWr;
        end
        SShWr: state_q <= SShRd;
        SMul1: state_q <= SMul2;
        SMul2: begin
          state_q <= SOut; out_valid_q <= 1'b1;
        end
        SOut: if (out_ready_i) begin
          state_q <= SIdle; out_valid_q <= 1'b0;
        end
        default: state_q <= SIdle;
      endcase
    end
  end
endmodule

// File: design/drfl_checker.sv
`include "dated_rate_floor_lookup_defines.svh"
module drfl_checker import drfl_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_item_o
);
  `DRFL_ASSERT_IMP(a_one_item, out_valid_o, !in_ready_o, "input open while result held")
  `DRFL_ASSERT_IMP(a_prod_zero, out_valid_o && (out_item_o.status != StOk), out_item_o.product == '0, "nonzero product")
  `DRFL_ASSERT_IMP(a_stat_range, out_valid_o, out_item_o.status <= StFull, "bad status code")
  `DRFL_ASSERT_NXT(a_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_item_o), "result dropped")
  `DRFL_ASSERT_NXT(a_in_hold, in_valid_i && !in_ready_o, in_valid_i, "input valid dropped")
endmodule

bind dated_rate_floor_lookup drfl_checker u_chk (.*);

// File: tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import drfl_pkg::*;

  // clock and reset
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #1 clk_i = ~clk_i;

  // block ports, inputs driven to known values from time zero
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_item;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [1:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  localparam logic [1:0] AddrAmountLimit = 2'd0;
  localparam int unsigned WatchdogLimit = 40000;

  dated_rate_floor_lookup u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // shadow of the rate table and the amount limit register
  logic [KeyW-1:0]   shadow_key  [TableDepth];
  logic [RateW-1:0]  shadow_rate [TableDepth];
  int unsigned       shadow_count;
  logic [LimitW-1:0] shadow_limit;

  out_item_t   pending_results[$];
  int unsigned mismatch_count;
  int unsigned status_seen[8];
  int unsigned items_sent;
  int unsigned idle_pct;   // sender gap chance per transaction
  int unsigned stall_pct;  // receiver stall chance per cycle
  int unsigned quiet_cycles;

  // four ascii digits of a number, first character in the top byte
  function automatic logic [31:0] ascii4(input int unsigned v);
    return {8'h30 + 8'(v / 1000), 8'h30 + 8'((v / 100) % 10),
            8'h30 + 8'((v / 10) % 10), 8'h30 + 8'(v % 10)};
  endfunction

  function automatic logic [15:0] ascii2(input int unsigned v);
    return {8'h30 + 8'(v / 10), 8'h30 + 8'(v % 10)};
  endfunction

  function automatic in_item_t mk_item(input logic op, input int unsigned y,
                                       input int unsigned m, input int unsigned d,
                                       input logic [31:0] amt, input logic [47:0] rate);
    in_item_t it;
    it.op = op;
    it.date_length = 4'd10;
    it.year_text = ascii4(y);
    it.first_dash = "-";
    it.month_text = ascii2(m);
    it.second_dash = "-";
    it.day_text = ascii2(d);
    it.amount = amt;
    it.rate_value = rate;
    return it;
  endfunction

  function automatic int unsigned days_in(input int unsigned y, input int unsigned m);
    if (m == 2) begin
      return ((y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0))) ? 29 : 28;
    end
    if (m == 4 || m == 6 || m == 9 || m == 11) begin
      return 30;
    end
    return 31;
  endfunction

  // checks every character, then the calendar
  function automatic bit date_is_valid(input in_item_t it);
    logic [63:0] text;
    int unsigned y, m, d;
    text = {it.year_text, it.month_text, it.day_text};
    if (it.date_length != 4'd10 || it.first_dash != "-" || it.second_dash != "-") begin
      return 1'b0;
    end
    for (int i = 0; i < 8; i++) begin
      if (text[8*i +: 8] < 8'h30 || text[8*i +: 8] > 8'h39) begin
        return 1'b0;
      end
    end
    y = 0;
    for (int i = 7; i >= 4; i--) begin
      y = y * 10 + (text[8*i +: 8] - 8'h30);
    end
    m = (text[31:24] - 8'h30) * 10 + (text[23:16] - 8'h30);
    d = (text[15:8] - 8'h30) * 10 + (text[7:0] - 8'h30);
    if (y == 0 || m < 1 || m > 12) begin
      return 1'b0;
    end
    return d >= 1 && d <= days_in(y, m);
  endfunction

  // number of stored keys not above the given key
  function automatic int unsigned keys_not_above(input logic [KeyW-1:0] k);
    int unsigned lo, hi, mid;
    lo = 0;
    hi = shadow_count;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (shadow_key[mid] <= k) begin
        lo = mid + 1;
      end else begin
        hi = mid;
      end
    end
    return lo;
  endfunction

  // applies one transaction to the shadow table and returns its result
  function automatic out_item_t predict_rate_result(input in_item_t it);
    out_item_t   res;
    logic [KeyW-1:0] k;
    int unsigned pos;
    logic [79:0] full_prod;
    res = '0;
    k = {it.year_text, it.month_text, it.day_text};
    pos = keys_not_above(k);
    if (it.op == OpLoad) begin
      if (pos > 0 && shadow_key[pos-1] == k) begin
        shadow_rate[pos-1] = it.rate_value;
        res.status = StLoaded;
      end else if (shadow_count >= TableDepth) begin
        res.status = StFull;
      end else begin
        for (int i = shadow_count; i > pos; i--) begin
          shadow_key[i] = shadow_key[i-1];
          shadow_rate[i] = shadow_rate[i-1];
        end
        shadow_key[pos] = k;
        shadow_rate[pos] = it.rate_value;
        shadow_count++;
        res.status = StLoaded;
      end
    end else if (!date_is_valid(it)) begin
      res.status = StBadDate;
    end else if (it.amount[31]) begin
      res.status = StNeg;
    end else if (it.amount[30:0] > shadow_limit) begin
      res.status = StBig;
    end else if (pos == 0) begin
      res.status = StNoRate;
    end else begin
      full_prod = 80'(it.amount[30:0]) * 80'(shadow_rate[pos-1]);
      res.status = StOk;
      res.product = full_prod[16 +: ProdW];
    end
    return res;
  endfunction

  // random date, mostly within a few decades so lookups land on loaded keys
  function automatic in_item_t rand_dated(input logic op);
    int unsigned y, m;
    y = ($urandom_range(0, 9) < 7) ? $urandom_range(2000, 2030) : $urandom_range(1, 9999);
    m = $urandom_range(1, 12);
    return mk_item(op, y, m, $urandom_range(1, days_in(y, m)), '0, '0);
  endfunction

  function automatic in_item_t rand_transaction();
    in_item_t it;
    logic [31:0] amt;
    if ($urandom_range(0, 99) < 25) begin
      it = rand_dated(OpLoad);
      if ($urandom_range(0, 9) == 0) begin
        // raw bit pattern as a key, kept below the fill range used at the end
        it = 165'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        it.op = OpLoad;
        it.year_text[31:24] = 8'($urandom_range(0, 254));
      end
      it.rate_value = 48'({$urandom, $urandom} >> $urandom_range(0, 40));
      return it;
    end
    it = rand_dated(OpQuery);
    case ($urandom_range(0, 15))
      0: it.date_length = 4'($urandom);
      1: it.first_dash = 8'($urandom);
      2: it.second_dash = 8'($urandom);
      3: it.year_text[8*$urandom_range(0, 3) +: 8] = 8'($urandom);
      4: it.month_text = ascii2($urandom_range(0, 1) ? 0 : $urandom_range(13, 99));
      5: it.day_text = ascii2($urandom_range(0, 1) ? 0 : $urandom_range(29, 99));
      6: it.year_text = ascii4(0);
      7: begin
        it.date_length = 4'($urandom);
        it.year_text = $urandom;
        it.month_text = 16'($urandom);
        it.day_text = 16'($urandom);
        it.first_dash = 8'($urandom);
        it.second_dash = 8'($urandom);
      end
      default: ;
    endcase
    case ($urandom_range(0, 9))
      0: amt = '0;
      1: amt = {1'b1, 31'($urandom)};
      2: amt = (shadow_limit == '1) ? {1'b0, 31'($urandom)}
                                    : 32'(shadow_limit) + 32'($urandom_range(1, 1000));
      3: amt = 32'(shadow_limit);
      default: amt = $urandom_range(0, shadow_limit);
    endcase
    it.amount = amt;
    it.rate_value = 48'({$urandom, $urandom});
    return it;
  endfunction

  // drives one transaction, holds it until accepted, then records the expectation
  task automatic send(input in_item_t it, input bit typed, input out_item_t typed_res);
    out_item_t res;
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < idle_pct);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk_i); while (!(in_valid && in_ready));
    res = predict_rate_result(it);
    pending_results.push_back(typed ? typed_res : res);
    items_sent++;
  endtask

  task automatic go_quiet();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // apb write then readback of the amount limit
  task automatic write_limit(input logic [30:0] value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= AddrAmountLimit;
    pwdata <= {1'b0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata[30:0] !== value) begin
      mismatch_count++;
      if (mismatch_count <= 10) begin
        $display("limit readback: expected %h actual %h", value, prdata);
      end
    end
    psel <= 1'b0;
    penable <= 1'b0;
    shadow_limit = value;
  endtask

  // receiver stalls at random
  always @(posedge clk_i) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // result checker against the oldest expectation
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("unexpected result: status %0d product %h", out_item.status,
                   out_item.product);
        end
      end else begin
        want = pending_results.pop_front();
        status_seen[out_item.status]++;
        if (out_item.status !== want.status || out_item.product !== want.product) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("result mismatch: expected status %0d product %h, actual %0d %h",
                     want.status, want.product, out_item.status, out_item.product);
          end
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_ni) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("watchdog expired with %0d results outstanding", pending_results.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  typedef struct {
    in_item_t  it;
    bit        typed;
    out_item_t res;
  } stim_row_t;

  initial begin
    stim_row_t rows[$];
    int unsigned idle_set[4] = '{0, 88, 0, 24};
    int unsigned stall_set[4] = '{0, 0, 88, 24};
    logic [30:0] limit_set[4];
    out_item_t none;
    in_item_t it;
    int unsigned fill;

    none = '0;
    quiet_cycles = 0;
    mismatch_count = 0;
    items_sent = 0;
    shadow_count = 0;
    shadow_limit = LimitReset;
    idle_pct = 0;
    stall_pct = 0;
    limit_set = '{LimitReset, 31'd0, 31'h7FFF_FFFF, 31'($urandom)};

    // directed rows: empty table, overwrite, date rules, amount edges, extremes
    rows.push_back('{mk_item(OpQuery, 2020, 1, 1, 32'h10000, '0), 1, '{StNoRate, '0}});
    rows.push_back('{mk_item(OpLoad, 2020, 1, 1, '0, 48'h18000), 1, '{StLoaded, '0}});
    rows.push_back('{mk_item(OpLoad, 2020, 1, 1, '0, 48'h20000), 1, '{StLoaded, '0}});
    rows.push_back('{mk_item(OpQuery, 2020, 1, 1, 32'h10000, '0), 1, '{StOk, 63'h20000}});
    rows.push_back('{mk_item(OpQuery, 2019, 12, 31, 32'h10000, '0), 1, '{StNoRate, '0}});
    rows.push_back('{mk_item(OpQuery, 2020, 6, 1, '0, '0), 1, '{StOk, '0}});
    rows.push_back('{mk_item(OpQuery, 2020, 6, 1, 32'h8000_0000, '0), 1, '{StNeg, '0}});
    rows.push_back('{mk_item(OpQuery, 2020, 6, 1, 32'(LimitReset) + 1, '0), 1,
                     '{StBig, '0}});
    rows.push_back('{mk_item(OpQuery, 2020, 6, 1, 32'(LimitReset), '0), 0, none});
    it = mk_item(OpQuery, 2020, 6, 1, 1, '0); it.date_length = 4'd9;
    rows.push_back('{it, 1, '{StBadDate, '0}});
    it = mk_item(OpQuery, 2020, 6, 1, 1, '0); it.date_length = 4'd15;
    rows.push_back('{it, 1, '{StBadDate, '0}});
    it = mk_item(OpQuery, 2020, 6, 1, 1, '0); it.first_dash = "/";
    rows.push_back('{it, 1, '{StBadDate, '0}});
    it = mk_item(OpQuery, 2020, 6, 1, 1, '0); it.second_dash = "/";
    rows.push_back('{it, 1, '{StBadDate, '0}});
    it = mk_item(OpQuery, 2020, 6, 1, 1, '0); it.year_text[15:8] = "a";
    rows.push_back('{it, 1, '{StBadDate, '0}});
    rows.push_back('{mk_item(OpQuery, 0, 6, 1, 1, '0), 1, '{StBadDate, '0}});
    rows.push_back('{mk_item(OpQuery, 2020, 13, 1, 1, '0), 1, '{StBadDate, '0}});
    rows.push_back('{mk_item(OpQuery, 2020, 0, 1, 1, '0), 1, '{StBadDate, '0}});
    rows.push_back('{mk_item(OpQuery, 2020, 6, 0, 1, '0), 1, '{StBadDate, '0}});
    rows.push_back('{mk_item(OpQuery, 2021, 2, 29, 1, '0), 1, '{StBadDate, '0}});
    rows.push_back('{mk_item(OpQuery, 1900, 2, 29, 1, '0), 1, '{StBadDate, '0}});
    rows.push_back('{mk_item(OpQuery, 2021, 4, 31, 1, '0), 1, '{StBadDate, '0}});
    rows.push_back('{mk_item(OpQuery, 2020, 2, 29, 32'h12345, '0), 0, none});
    rows.push_back('{mk_item(OpLoad, 9999, 12, 31, '0, '1), 1, '{StLoaded, '0}});
    rows.push_back('{mk_item(OpQuery, 9999, 12, 31, 32'(LimitReset), '0), 0, none});
    rows.push_back('{in_item_t'('0), 1, '{StLoaded, '0}});

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    foreach (rows[i]) begin
      send(rows[i].it, rows[i].typed, rows[i].res);
    end
    go_quiet();

    // random phases, each with its own idling mix and limit setting
    for (int p = 0; p < 4; p++) begin
      idle_pct = idle_set[p];
      stall_pct = stall_set[p];
      write_limit(limit_set[p]);
      for (int n = 0; n < 370; n++) begin
        // one drain in the middle so the block sees a fully idle input
        if (p == 1 && n == 185) begin
          go_quiet();
        end
        send(rand_transaction(), 0, none);
      end
      go_quiet();
    end

    // fill the table with ascending keys above all others, then overflow it
    idle_pct = 0;
    stall_pct = 0;
    write_limit(31'h7FFF_FFFF);
    fill = 0;
    while (shadow_count < TableDepth) begin
      it = '0;
      it.year_text = {8'hFF, 24'(fill)};
      it.rate_value = {$urandom, 16'($urandom)};
      send(it, 1, '{StLoaded, '0});
      fill++;
    end
    it = '1;
    it.op = OpLoad;
    send(it, 1, '{StFull, '0});
    it = '0;
    it.rate_value = 48'h1;
    send(it, 1, '{StLoaded, '0});
    send(mk_item(OpQuery, 2025, 3, 15, 32'h7FFF_FFFF, '0), 0, none);
    go_quiet();
    repeat (50) @(posedge clk_i);

    $display("%0d transactions sent over four idling mixes and a full-table fill",
             items_sent);
    $display("results: ok %0d, bad date %0d, negative %0d, too large %0d, no rate %0d",
             status_seen[StOk], status_seen[StBadDate], status_seen[StNeg],
             status_seen[StBig], status_seen[StNoRate]);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
